>>> rtl/bmhq_pkg.sv
package bmhq_pkg;

   // one stored entry: weight in the upper bits, tag below
   typedef struct packed {
      logic [31:0] weight;
      logic [15:0] tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_POP    = 1'b1;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic start_ins;   // capture insert word, open hole at the end
      logic start_full;  // insert dropped, heap full
      logic start_empty; // pop on empty heap
      logic start_pop;   // read root and last entry
      logic rd_up;       // read parent of hole
      logic up_step;     // move parent down into hole
      logic place;       // write held entry into hole
      logic pop_load;    // latch root as result, last entry as held entry
      logic rd_dn;       // read both children of hole
      logic dn_step;     // move smaller child up into hole
      logic rsp_load;    // present staged result
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic last_one;    // exactly one entry held
      logic pos_zero;    // hole is at the root
      logic up_move;     // held weight below parent weight
      logic dn_move;     // a child is lighter than held weight
      logic rsp_free;    // response register can take a word
   } stat_type;

endpackage

>>> rtl/bmhq_ram.sv
module bmhq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> rtl/bmhq_datapath.sv
module bmhq_datapath import bmhq_pkg::*; #(
   parameter int HEAP_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [31:0] req_key_weight,
   input  logic [15:0] req_entry_tag,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [31:0] rsp_out_weight,
   output logic [15:0] rsp_out_tag,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_occupancy
);

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);

   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  pos_ff, pos_in;
   entry_type      held_ff, held_in;
   entry_type      res_ff, res_in;
   logic [1:0]     st_ff, st_in;

   logic           rsp_valid_ff, rsp_valid_in;
   entry_type      rsp_ent_ff, rsp_ent_in;
   logic [1:0]     rsp_st_ff, rsp_st_in;
   logic [CW-1:0]  rsp_cnt_ff, rsp_cnt_in;

   logic [AW-1:0]  parent;
   logic [AW:0]    lc, rc;
   logic           lc_ok, rc_ok, take_l, take_r;
   logic [31:0]    best_w;
   entry_type      rd_a, rd_b, child;
   logic [AW:0]    child_idx;

   logic           wr_en;
   logic [AW-1:0]  wr_addr, rd_addr_a, rd_addr_b;
   entry_type      wr_data;
   logic [ENTRY_W-1:0] rd_a_raw, rd_b_raw;

   assign rd_a = entry_type'(rd_a_raw);
   assign rd_b = entry_type'(rd_b_raw);

   // tree addressing around the hole
   assign parent = AW'((pos_ff - 1'b1) >> 1);
   assign lc     = {pos_ff, 1'b1};
   assign rc     = {pos_ff, 1'b0} + (AW+1)'(2);
   assign lc_ok  = (AW+2)'(lc) < (AW+2)'(count_ff);
   assign rc_ok  = (AW+2)'(rc) < (AW+2)'(count_ff);

   // sift-down choice: left if strictly lighter, right if lighter still
   assign take_l    = lc_ok && (rd_a.weight < held_ff.weight);
   assign best_w    = take_l ? rd_a.weight : held_ff.weight;
   assign take_r    = rc_ok && (rd_b.weight < best_w);
   assign child     = take_r ? rd_b : rd_a;
   assign child_idx = take_r ? rc : lc;

   // status to controller
   always_comb begin
      stat.full     = count_ff == CW'(HEAP_DEPTH);
      stat.empty    = count_ff == '0;
      stat.last_one = count_ff == CW'(1);
      stat.pos_zero = pos_ff == '0;
      stat.up_move  = held_ff.weight < rd_a.weight;
      stat.dn_move  = take_l || take_r;
      stat.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   // memory port selection
   always_comb begin
      rd_addr_a = parent;
      rd_addr_b = AW'(count_ff - 1'b1);
      if (cmd.start_pop) begin
         rd_addr_a = '0;
      end else if (cmd.rd_up) begin
         rd_addr_a = parent;
      end else if (cmd.rd_dn) begin
         rd_addr_a = AW'(lc);
         rd_addr_b = AW'(rc);
      end
      wr_en   = cmd.place || cmd.up_step || cmd.dn_step;
      wr_addr = pos_ff;
      if (cmd.place) begin
         wr_data = held_ff;
      end else if (cmd.up_step) begin
         wr_data = rd_a;
      end else begin
         wr_data = child;
      end
   end

   bmhq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (HEAP_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_a_raw),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_b_raw)
   );

   // working registers
   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      held_in  = held_ff;
      res_in   = res_ff;
      st_in    = st_ff;
      if (cmd.start_ins) begin
         held_in  = '{weight: req_key_weight, tag: req_entry_tag};
         pos_in   = AW'(count_ff);
         count_in = count_ff + 1'b1;
         res_in   = '0;
         st_in    = ST_OK;
      end
      if (cmd.start_full) begin
         res_in = '0;
         st_in  = ST_FULL;
      end
      if (cmd.start_empty) begin
         res_in = '0;
         st_in  = ST_EMPTY;
      end
      if (cmd.start_pop) begin
         st_in = ST_OK;
      end
      if (cmd.pop_load) begin
         res_in   = rd_a;
         held_in  = rd_b;
         count_in = count_ff - 1'b1;
         pos_in   = '0;
      end
      if (cmd.up_step) begin
         pos_in = parent;
      end
      if (cmd.dn_step) begin
         pos_in = AW'(child_idx);
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ent_in   = rsp_ent_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_ent_in   = res_ff;
         rsp_st_in    = st_ff;
         rsp_cnt_in   = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff     <= pos_in;
      held_ff    <= held_in;
      res_ff     <= res_in;
      st_ff      <= st_in;
      rsp_ent_ff <= rsp_ent_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_weight = rsp_ent_ff.weight;
   assign rsp_out_tag    = rsp_ent_ff.tag;
   assign rsp_status     = rsp_st_ff;
   assign rsp_occupancy  = 9'(rsp_cnt_ff);

endmodule

>>> rtl/bmhq_ctrl.sv
module bmhq_ctrl import bmhq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_kind,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UP_RD  = 3'd1;
   localparam logic [2:0] S_UP_CMP = 3'd2;
   localparam logic [2:0] S_POP_LD = 3'd3;
   localparam logic [2:0] S_DN_RD  = 3'd4;
   localparam logic [2:0] S_DN_CMP = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_INSERT) begin
                  if (stat.full) begin
                     cmd.start_full = 1'b1;
                     state_in       = S_RESP;
                  end else begin
                     cmd.start_ins = 1'b1;
                     state_in      = S_UP_RD;
                  end
               end else begin
                  if (stat.empty) begin
                     cmd.start_empty = 1'b1;
                     state_in        = S_RESP;
                  end else begin
                     cmd.start_pop = 1'b1;
                     state_in      = S_POP_LD;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (stat.pos_zero) begin
               cmd.place = 1'b1;
               state_in  = S_RESP;
            end else begin
               cmd.rd_up = 1'b1;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.up_move) begin
               cmd.up_step = 1'b1;
               state_in    = S_UP_RD;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_RESP;
            end
         end
         S_POP_LD: begin
            cmd.pop_load = 1'b1;
            state_in     = stat.last_one ? S_RESP : S_DN_RD;
         end
         S_DN_RD: begin
            cmd.rd_dn = 1'b1;
            state_in  = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (stat.dn_move) begin
               cmd.dn_step = 1'b1;
               state_in    = S_DN_RD;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_RESP;
            end
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/binary_min_heap_queue.sv
// Channel   Ports                                              Direction
// request   req_valid req_ready req_kind req_key_weight        in
//           req_entry_tag
// response  rsp_valid rsp_ready rsp_out_weight rsp_out_tag     out
//           rsp_status rsp_occupancy
//
// One word at a time. Insert: read and compare per level climbed, then place;
// pop: read root and last entry, load, then unless that was the last entry,
// read and compare per level descended, then place; full or empty: to S_RESP.
// The pace is set by the registered read of the heap RAM in each level step.
// Synchronous active-high reset empties the heap; RAM contents are not cleared.
// A result waits in the response register; it is handed in only once the word
// before it is taken, and the next request is taken right after that.
module binary_min_heap_queue import bmhq_pkg::*; #(
   parameter int HEAP_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [31:0] req_key_weight,
   input  logic [15:0] req_entry_tag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_weight,
   output logic [15:0] rsp_out_tag,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_occupancy
);

   cmd_type  cmd;
   stat_type stat;

   bmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bmhq_datapath #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_key_weight (req_key_weight),
      .req_entry_tag  (req_entry_tag),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_out_weight (rsp_out_weight),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

// one expected response word
typedef struct {
   logic [31:0] weight;
   logic [15:0] tag;
   logic [1:0]  status;
   logic [8:0]  occupancy;
} heap_result_type;

// shadow copy of the heap; predicts each response word and checks it
class heap_shadow #(int SLOTS = 256);
   bmhq_pkg::entry_type slots [SLOTS];
   int unsigned held = 0;
   heap_result_type owed [$];
   int unsigned errors = 0;

   // apply one accepted request word and queue the response it owes
   function void note_request(logic kind, logic [31:0] weight, logic [15:0] tag);
      heap_result_type r;
      bmhq_pkg::entry_type moving;
      int unsigned pos;
      int unsigned par;
      int unsigned best;
      int unsigned lc;
      int unsigned rc;
      r.weight = 32'd0;
      r.tag = 16'd0;
      r.status = bmhq_pkg::ST_OK;
      if (kind == bmhq_pkg::KIND_INSERT) begin
         if (held >= SLOTS) begin
            r.status = bmhq_pkg::ST_FULL;
         end else begin
            moving.weight = weight;
            moving.tag = tag;
            pos = held;
            held++;
            // climb while strictly lighter than the parent
            while (pos > 0) begin
               par = (pos - 1) / 2;
               if (!(weight < slots[par].weight)) break;
               slots[pos] = slots[par];
               pos = par;
            end
            slots[pos] = moving;
         end
      end else if (held == 0) begin
         r.status = bmhq_pkg::ST_EMPTY;
      end else begin
         r.weight = slots[0].weight;
         r.tag = slots[0].tag;
         held--;
         if (held > 0) begin
            slots[0] = slots[held];
            pos = 0;
            // sink: left child if strictly lighter, then right if lighter still
            while (1) begin
               best = pos;
               lc = 2 * pos + 1;
               rc = 2 * pos + 2;
               if (lc < held && slots[lc].weight < slots[best].weight) best = lc;
               if (rc < held && slots[rc].weight < slots[best].weight) best = rc;
               if (best == pos) break;
               moving = slots[best];
               slots[best] = slots[pos];
               slots[pos] = moving;
               pos = best;
            end
         end
      end
      r.occupancy = held[8:0];
      owed.push_back(r);
   endfunction

   // compare one accepted response word against the oldest owed one
   function void check_response(logic [31:0] weight, logic [15:0] tag,
                                logic [1:0] status, logic [8:0] occupancy);
      heap_result_type want;
      if (owed.size() == 0) begin
         $display("%0t: response word with none owed: weight %h tag %h status %0d occ %0d",
                  $time, weight, tag, status, occupancy);
         errors++;
         return;
      end
      want = owed.pop_front();
      if (want.weight !== weight) begin
         $display("%0t: out_weight expected %h actual %h", $time, want.weight, weight);
         errors++;
      end
      if (want.tag !== tag) begin
         $display("%0t: out_tag expected %h actual %h", $time, want.tag, tag);
         errors++;
      end
      if (want.status !== status) begin
         $display("%0t: status expected %0d actual %0d", $time, want.status, status);
         errors++;
      end
      if (want.occupancy !== occupancy) begin
         $display("%0t: occupancy expected %0d actual %0d",
                  $time, want.occupancy, occupancy);
         errors++;
      end
   endfunction
endclass

module tb;
   import bmhq_pkg::*;

   localparam int HEAP_DEPTH = 256;
   localparam int ITEM_TARGET = 1550;
   localparam int QUIET_LIMIT = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_INSERT;
   logic [31:0] req_key_weight = 32'd0;
   logic [15:0] req_entry_tag = 16'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_out_weight;
   logic [15:0] rsp_out_tag;
   logic [1:0]  rsp_status;
   logic [8:0]  rsp_occupancy;

   heap_shadow #(HEAP_DEPTH) shadow = new;

   int unsigned words_sent = 0;
   int unsigned burst_left = 0;
   int unsigned gap_max = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_left = 0;
   int unsigned ready_style = 0;
   int unsigned style_age = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   binary_min_heap_queue #(.HEAP_DEPTH(HEAP_DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_key_weight (req_key_weight),
      .req_entry_tag  (req_entry_tag),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_weight (rsp_out_weight),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         shadow.check_response(rsp_out_weight, rsp_out_tag, rsp_status, rsp_occupancy);
   end

   // watchdog: too long without any word moving
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // receiver backpressure in one of three styles, redrawn at random
   always @(posedge clock) begin
      style_age++;
      if (style_age >= 250) begin
         style_age = 0;
         ready_style = $urandom_range(0, 2);
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= 1'b1;
         case (ready_style)
            1: if ($urandom_range(0, 2) == 0) hold_left = $urandom_range(1, 3);
            2: if ($urandom_range(0, 15) == 0) hold_left = $urandom_range(5, 25);
            default: ;
         endcase
      end
   end

   // present one request word and hold it until taken; gaps between bursts
   task automatic send_word(input logic kind, input logic [31:0] weight,
                            input logic [15:0] tag);
      int unsigned gap;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_key_weight <= weight;
      req_entry_tag <= tag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shadow.note_request(kind, weight, tag);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else if (gap_max > 0) begin
         gap = $urandom_range(1, gap_max);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   // stop sending until every owed response has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (shadow.owed.size() != 0) @(posedge clock);
   endtask

   // weights skewed toward ties and the ends of the range
   function automatic logic [31:0] pick_weight();
      case ($urandom_range(0, 9))
         0, 1: return $urandom_range(0, 7);
         2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         3: return 32'hFFFF_FFFF - $urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   task automatic run_mix(input int unsigned count, input int unsigned insert_pct);
      int unsigned i;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < insert_pct)
            send_word(KIND_INSERT, pick_weight(), 16'($urandom_range(0, 65535)));
         else
            send_word(KIND_POP, $urandom, 16'($urandom_range(0, 65535)));
      end
   endtask

   // insert until full, then a few that must be dropped
   task automatic run_fill();
      int unsigned extra;
      extra = $urandom_range(1, 4);
      while (shadow.held < HEAP_DEPTH)
         send_word(KIND_INSERT, pick_weight(), 16'($urandom_range(0, 65535)));
      repeat (extra) send_word(KIND_INSERT, $urandom, 16'($urandom_range(0, 65535)));
   endtask

   // pop until empty, then a few pops on the empty heap
   task automatic run_drain();
      int unsigned extra;
      extra = $urandom_range(1, 3);
      while (shadow.held > 0) send_word(KIND_POP, $urandom, 16'($urandom_range(0, 65535)));
      repeat (extra) send_word(KIND_POP, $urandom, 16'($urandom_range(0, 65535)));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, extreme fields, ties, single-entry pop
      gap_max = 0;
      send_word(KIND_POP, 32'hDEAD_BEEF, 16'hBEEF);
      send_word(KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(KIND_INSERT, 32'h0, 16'h0000);
      send_word(KIND_INSERT, 32'h0, 16'h0001);
      send_word(KIND_INSERT, 32'd7, 16'hAAAA);
      send_word(KIND_INSERT, 32'd7, 16'h5555);
      send_word(KIND_INSERT, 32'd7, 16'h1234);
      send_word(KIND_INSERT, 32'h8000_0000, 16'h8000);
      send_word(KIND_INSERT, 32'd1, 16'h0001);
      repeat (8) send_word(KIND_POP, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(KIND_POP, 32'h0, 16'h0);
      send_word(KIND_INSERT, 32'd5, 16'hABCD);
      send_word(KIND_POP, 32'h0, 16'h0);
      wait_for_drain();

      // random: mixed traffic, then a full fill and drain, then random phases
      gap_max = 6;
      run_mix(150, 60);
      wait_for_drain();
      gap_max = 0;
      run_fill();
      gap_max = 10;
      run_drain();
      while (words_sent < ITEM_TARGET) begin
         gap_max = $urandom_range(0, 2) * 6;
         case ($urandom_range(0, 3))
            0: run_fill();
            1: run_drain();
            default: run_mix($urandom_range(50, 200), $urandom_range(35, 75));
         endcase
         if ($urandom_range(0, 3) == 0) wait_for_drain();
      end

      wait_for_drain();
      repeat (40) @(posedge clock);
      if (shadow.errors == 0 && shadow.owed.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule
